FILE: hdl/mep_pkg.sv
// shared types, widths and constants for the escape-time pixel core
package mep_pkg;

  // arithmetic sizes
  localparam int COORD_WIDTH     = 64;
  localparam int ITER_WIDTH      = 16;
  localparam int DIM_WIDTH       = 16;
  localparam int FRAC_BITS       = COORD_WIDTH - 8;
  localparam int STEP_WIDTH      = COORD_WIDTH - 1;
  localparam int HALF_WIDTH      = COORD_WIDTH / 2;
  localparam int PROD_WIDTH      = 2 * COORD_WIDTH;
  localparam int OFS_WIDTH       = DIM_WIDTH + 2;

  // color and divider sizes
  localparam int CHAN_WIDTH      = 8;
  localparam int NUM_CHAN        = 3;
  localparam int COLOR_WIDTH     = CHAN_WIDTH * NUM_CHAN;
  localparam int DIVIDEND_WIDTH  = CHAN_WIDTH + ITER_WIDTH;

  // port field sizes
  localparam int PIXEL_WIDTH     = 16;
  localparam int COUNT_WIDTH     = 16;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 64;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // destination of a product leaving the multiplier
  typedef enum logic [2:0] {
    TAG_OFS_X,
    TAG_OFS_Y,
    TAG_CROSS,
    TAG_SQ_X,
    TAG_SQ_Y
  } mep_tag_t;

  typedef struct packed {
    logic [PIXEL_WIDTH-1:0] pixel_x;
    logic [PIXEL_WIDTH-1:0] pixel_y;
  } mep_in_t;

  typedef struct packed {
    logic [COLOR_WIDTH-1:0] pixel_color;
    logic [COUNT_WIDTH-1:0] iteration_count;
    logic                   escaped;
  } mep_out_t;

  typedef struct packed {
    logic     capture;
    logic     mul_go;
    mep_tag_t mul_tag;
    logic     seed;
    logic     step;
    logic     div_start;
    logic     out_load;
  } mep_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic keep_going;
    logic below_lim;
  } mep_status_t;

endpackage

FILE: hdl/mep_mul.sv
// pipelined signed fixed-point multiplier built from half-width partial products
module mep_mul
  import mep_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     go,
  input  mep_tag_t tag,
  input  coord_t   op_a,
  input  coord_t   op_b,
  output logic     busy,
  output logic     res_valid,
  output mep_tag_t res_tag,
  output coord_t   res
);

  logic [COORD_WIDTH-1:0] mag_a;
  logic [COORD_WIDTH-1:0] mag_b;
  logic                   v1_r, v2_r, v3_r;
  logic                   neg1_r, neg2_r, neg3_r;
  mep_tag_t               tag1_r, tag2_r, tag3_r;
  logic [COORD_WIDTH-1:0] mag_a_r, mag_b_r;
  logic [COORD_WIDTH-1:0] pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic [PROD_WIDTH-1:0]  prod_r;
  logic                   over;
  logic [COORD_WIDTH-1:0] mag;

  assign mag_a = op_a[COORD_WIDTH-1] ? (~op_a) + COORD_WIDTH'(1) : op_a;
  assign mag_b = op_b[COORD_WIDTH-1] ? (~op_b) + COORD_WIDTH'(1) : op_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= go;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    // operand magnitudes
    mag_a_r <= mag_a;
    mag_b_r <= mag_b;
    neg1_r  <= op_a[COORD_WIDTH-1] ^ op_b[COORD_WIDTH-1];
    tag1_r  <= tag;
    // partial products
    pp_ll_r <= mag_a_r[HALF_WIDTH-1:0] * mag_b_r[HALF_WIDTH-1:0];
    pp_lh_r <= mag_a_r[HALF_WIDTH-1:0] * mag_b_r[COORD_WIDTH-1:HALF_WIDTH];
    pp_hl_r <= mag_a_r[COORD_WIDTH-1:HALF_WIDTH] * mag_b_r[HALF_WIDTH-1:0];
    pp_hh_r <= mag_a_r[COORD_WIDTH-1:HALF_WIDTH] * mag_b_r[COORD_WIDTH-1:HALF_WIDTH];
    neg2_r  <= neg1_r;
    tag2_r  <= tag1_r;
    // full product
    prod_r  <= PROD_WIDTH'(pp_ll_r)
             + (PROD_WIDTH'(pp_lh_r) << HALF_WIDTH)
             + (PROD_WIDTH'(pp_hl_r) << HALF_WIDTH)
             + (PROD_WIDTH'(pp_hh_r) << COORD_WIDTH);
    neg3_r  <= neg2_r;
    tag3_r  <= tag2_r;
  end

  // drop fraction bits (only the halving bit for the offset products), then saturate the signed result
  always_comb begin
    if (tag3_r == TAG_OFS_X || tag3_r == TAG_OFS_Y) begin
      over = |prod_r[PROD_WIDTH-1:COORD_WIDTH+1];
      mag  = prod_r[COORD_WIDTH:1];
    end else begin
      over = |prod_r[PROD_WIDTH-1:COORD_WIDTH+FRAC_BITS];
      mag  = prod_r[COORD_WIDTH+FRAC_BITS-1:FRAC_BITS];
    end
    if (over || mag[COORD_WIDTH-1]) begin
      res = neg3_r ? CMIN : CMAX;
    end else begin
      res = neg3_r ? coord_t'((~mag) + COORD_WIDTH'(1)) : coord_t'(mag);
    end
  end

  assign busy      = v1_r | v2_r | v3_r;
  assign res_valid = v3_r;
  assign res_tag   = tag3_r;

endmodule

FILE: hdl/mep_div.sv
// three-lane restoring divider, one quotient bit per cycle
module mep_div
  import mep_pkg::*;
(
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic [NUM_CHAN-1:0][DIVIDEND_WIDTH-1:0]  dividend,
  input  logic [ITER_WIDTH-1:0]                    divisor,
  output logic                                     busy,
  output logic [NUM_CHAN-1:0][CHAN_WIDTH-1:0]      quotient
);

  localparam int CNT_WIDTH = $clog2(DIVIDEND_WIDTH + 1);

  logic                                     busy_r;
  logic [CNT_WIDTH-1:0]                     cnt_r;
  logic [NUM_CHAN-1:0][ITER_WIDTH-1:0]      rem_r, rem_nxt;
  logic [NUM_CHAN-1:0][DIVIDEND_WIDTH-1:0]  quo_r, quo_nxt;

  always_comb begin
    logic [ITER_WIDTH:0] trial;
    trial = '0;
    for (int k = 0; k < NUM_CHAN; k++) begin
      trial = {rem_r[k], quo_r[k][DIVIDEND_WIDTH-1]};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt[k] = ITER_WIDTH'(trial - {1'b0, divisor});
        quo_nxt[k] = {quo_r[k][DIVIDEND_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[ITER_WIDTH-1:0];
        quo_nxt[k] = {quo_r[k][DIVIDEND_WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_WIDTH'(DIVIDEND_WIDTH);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_WIDTH'(1);
      if (cnt_r == CNT_WIDTH'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      quotient[k] = quo_r[k][CHAN_WIDTH-1:0];
    end
  end

  assign busy = busy_r;

endmodule

FILE: hdl/mep_datapath.sv
// datapath: config registers, point mapping, z iteration registers and color
module mep_datapath
  import mep_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  mep_in_t                    in_data,
  input  mep_cmd_t                   cmd,
  output mep_status_t                st,
  output mep_out_t                   out_data
);

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_REAL  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_IMAG  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PIXEL_STEP   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_ITER     = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IMAGE_WIDTH  = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IMAGE_HEIGHT = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COLOR_LOW    = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COLOR_HIGH   = 3'd7;

  localparam coord_t                CENTER_REAL_RST = {{9{1'b1}}, {(FRAC_BITS-1){1'b0}}};
  localparam logic [STEP_WIDTH-1:0] STEP_RST        = STEP_WIDTH'(1) << (FRAC_BITS - 8);
  localparam logic [COORD_WIDTH:0]  FOUR            =
    {{(COORD_WIDTH-2-FRAC_BITS){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

  function automatic coord_t sat_add(coord_t a, coord_t b);
    logic [COORD_WIDTH:0] s;
    s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
    if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
      return s[COORD_WIDTH] ? CMIN : CMAX;
    end
    return coord_t'(s[COORD_WIDTH-1:0]);
  endfunction

  function automatic coord_t sat_sub(coord_t a, coord_t b);
    logic [COORD_WIDTH:0] s;
    s = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
    if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
      return s[COORD_WIDTH] ? CMIN : CMAX;
    end
    return coord_t'(s[COORD_WIDTH-1:0]);
  endfunction

  // configuration
  coord_t                   center_real_r, center_imag_r;
  logic [STEP_WIDTH-1:0]    pixel_step_r;
  logic [ITER_WIDTH-1:0]    max_iter_r;
  logic [DIM_WIDTH-1:0]     image_width_r, image_height_r;
  logic [COLOR_WIDTH-1:0]   color_low_r, color_high_r;

  // per-pixel working registers
  logic [DIM_WIDTH-1:0]     px_r, py_r;
  coord_t                   ofs_x_r, ofs_y_r, re_r, im_r;
  coord_t                   zx_r, zy_r, cross_r, sq_x_r, sq_y_r;
  logic [ITER_WIDTH-1:0]    iter_r;
  logic [NUM_CHAN-1:0]      dneg_r;
  mep_out_t                 out_data_r;

  logic signed [OFS_WIDTH-1:0]              n_x, n_y;
  coord_t                                   op_a, op_b;
  logic                                     mul_busy, res_valid;
  mep_tag_t                                 res_tag;
  coord_t                                   res;
  logic [COORD_WIDTH:0]                     mag2;
  logic                                     below_lim;
  logic [NUM_CHAN-1:0]                      chan_neg;
  logic [NUM_CHAN-1:0][DIVIDEND_WIDTH-1:0]  dividend;
  logic [NUM_CHAN-1:0][CHAN_WIDTH-1:0]      quotient;
  logic [NUM_CHAN-1:0][CHAN_WIDTH-1:0]      chan_color;
  logic                                     div_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_real_r  <= CENTER_REAL_RST;
      center_imag_r  <= '0;
      pixel_step_r   <= STEP_RST;
      max_iter_r     <= ITER_WIDTH'(256);
      image_width_r  <= DIM_WIDTH'(640);
      image_height_r <= DIM_WIDTH'(480);
      color_low_r    <= '0;
      color_high_r   <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_REAL:  center_real_r  <= coord_t'(cfg_data[COORD_WIDTH-1:0]);
        CFG_CENTER_IMAG:  center_imag_r  <= coord_t'(cfg_data[COORD_WIDTH-1:0]);
        CFG_PIXEL_STEP:   pixel_step_r   <= cfg_data[STEP_WIDTH-1:0];
        CFG_MAX_ITER:     max_iter_r     <= cfg_data[ITER_WIDTH-1:0];
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[DIM_WIDTH-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data[DIM_WIDTH-1:0];
        CFG_COLOR_LOW:    color_low_r    <= cfg_data[COLOR_WIDTH-1:0];
        CFG_COLOR_HIGH:   color_high_r   <= cfg_data[COLOR_WIDTH-1:0];
      endcase
    end
  end

  // twice the centered pixel index, the halving is folded into the product
  assign n_x = {1'b0, px_r, 1'b0} - {2'b00, image_width_r};
  assign n_y = {1'b0, py_r, 1'b0} - {2'b00, image_height_r};

  always_comb begin
    case (cmd.mul_tag)
      TAG_OFS_X: begin
        op_a = coord_t'(n_x);
        op_b = coord_t'({1'b0, pixel_step_r});
      end
      TAG_OFS_Y: begin
        op_a = coord_t'(n_y);
        op_b = coord_t'({1'b0, pixel_step_r});
      end
      TAG_SQ_X: begin
        op_a = zx_r;
        op_b = zx_r;
      end
      TAG_SQ_Y: begin
        op_a = zy_r;
        op_b = zy_r;
      end
      default: begin
        op_a = zx_r;
        op_b = zy_r;
      end
    endcase
  end

  mep_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (cmd.mul_go),
    .tag       (cmd.mul_tag),
    .op_a      (op_a),
    .op_b      (op_b),
    .busy      (mul_busy),
    .res_valid (res_valid),
    .res_tag   (res_tag),
    .res       (res)
  );

  // escape test, squares are never negative
  assign mag2      = {1'b0, sq_x_r} + {1'b0, sq_y_r};
  assign below_lim = iter_r < max_iter_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r <= in_data.pixel_x[DIM_WIDTH-1:0];
      py_r <= in_data.pixel_y[DIM_WIDTH-1:0];
    end
    if (cmd.seed) begin
      re_r    <= sat_add(center_real_r, ofs_x_r);
      im_r    <= sat_sub(center_imag_r, ofs_y_r);
      zx_r    <= '0;
      zy_r    <= '0;
      cross_r <= '0;
      sq_x_r  <= '0;
      sq_y_r  <= '0;
      iter_r  <= '0;
    end else if (cmd.step) begin
      zy_r   <= sat_add(sat_add(cross_r, cross_r), im_r);
      zx_r   <= sat_add(sat_sub(sq_x_r, sq_y_r), re_r);
      iter_r <= iter_r + ITER_WIDTH'(1);
    end else if (res_valid) begin
      case (res_tag)
        TAG_OFS_X: ofs_x_r <= res;
        TAG_OFS_Y: ofs_y_r <= res;
        TAG_CROSS: cross_r <= res;
        TAG_SQ_X:  sq_x_r  <= res;
        TAG_SQ_Y:  sq_y_r  <= res;
        default: ;
      endcase
    end
    if (cmd.div_start) begin
      dneg_r <= chan_neg;
    end
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt_f(below_lim);
    end
  end

  // gradient: |high - low| * count feeds the divider, sign kept aside
  always_comb begin
    logic [CHAN_WIDTH-1:0] lo_c, hi_c, dmag;
    for (int k = 0; k < NUM_CHAN; k++) begin
      lo_c        = color_low_r[k*CHAN_WIDTH +: CHAN_WIDTH];
      hi_c        = color_high_r[k*CHAN_WIDTH +: CHAN_WIDTH];
      chan_neg[k] = hi_c < lo_c;
      dmag        = chan_neg[k] ? lo_c - hi_c : hi_c - lo_c;
      dividend[k] = DIVIDEND_WIDTH'(dmag) * DIVIDEND_WIDTH'(iter_r);
      chan_color[k] = dneg_r[k] ? lo_c - quotient[k] : lo_c + quotient[k];
    end
  end

  mep_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (max_iter_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  function automatic mep_out_t out_data_nxt_f(logic esc);
    mep_out_t o;
    o.pixel_color     = esc ? chan_color : '0;
    o.iteration_count = COUNT_WIDTH'(iter_r);
    o.escaped         = esc;
    return o;
  endfunction

  assign st.mul_busy   = mul_busy;
  assign st.div_busy   = div_busy;
  assign st.below_lim  = below_lim;
  assign st.keep_going = (mag2 <= FOUR) && below_lim;
  assign out_data      = out_data_r;

  a_iter_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> iter_r <= max_iter_r)
    else $error("iteration count ran past the limit");

endmodule

FILE: hdl/mep_ctrl.sv
// controller: sequences offsets, the iteration loop, color division and output
module mep_ctrl
  import mep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  mep_status_t st,
  output mep_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFS_X,
    ST_OFS_Y,
    ST_OFS_WAIT,
    ST_SEED,
    ST_LOOP,
    ST_SQ_CROSS,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_WAIT,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.mul_tag   = TAG_CROSS;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_OFS_X;
        end
      end
      ST_OFS_X: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_tag = TAG_OFS_X;
        state_nxt   = ST_OFS_Y;
      end
      ST_OFS_Y: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_tag = TAG_OFS_Y;
        state_nxt   = ST_OFS_WAIT;
      end
      ST_OFS_WAIT: begin
        if (!st.mul_busy) begin
          state_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = ST_LOOP;
      end
      ST_LOOP: begin
        if (st.keep_going) begin
          cmd.step  = 1'b1;
          state_nxt = ST_SQ_CROSS;
        end else if (st.below_lim) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SQ_CROSS: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_tag = TAG_CROSS;
        state_nxt   = ST_SQ_X;
      end
      ST_SQ_X: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_tag = TAG_SQ_X;
        state_nxt   = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_tag = TAG_SQ_Y;
        state_nxt   = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (!st.mul_busy) begin
          state_nxt = ST_LOOP;
        end
      end
      ST_DIV: begin
        if (!st.div_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  a_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second pixel taken while one is in work");

  a_mul_div_apart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_go |-> !st.div_busy)
    else $error("multiplier issued during color division");

  a_products_landed: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.seed || cmd.step || cmd.div_start) |-> !st.mul_busy)
    else $error("z registers used before products landed");

endmodule

FILE: hdl/mandelbrot_escape_time_pixel_core.sv
// top level of the escape-time pixel core: controller plus datapath
//
// Each input beat names one pixel (pixel_x, pixel_y). The core maps it to
// c = (center_real + (x - width/2)*step) + i*(center_imag - (y - height/2)*step),
// iterates z = z^2 + c from zero in saturating signed Q8.56 until |z|^2 > 4
// or the count reaches max_iter, and returns one result beat with the color,
// the count and the escape flag. Escaped pixels blend color_low toward
// color_high by count/max_iter per channel, truncated toward zero; pixels
// that reach the limit are black. One pixel is in work at a time. The loop
// time is set by one shared 64x64 multiplier, four 32x32 partial products
// with three register stages, through which the cross term and both
// squares of every iteration pass in turn; the color uses a three-lane
// divider that makes one quotient bit per cycle. The result sits in an
// output register, so the next pixel is taken while the last result still
// waits on out_ready. Configuration writes go straight to the registers;
// the user must make them only while the core is idle, as the core itself
// does not enforce it.
module mandelbrot_escape_time_pixel_core
  import mep_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // pixel beats in
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mep_in_t                    in_data,
  // result beats out
  output logic                       out_valid,
  input  logic                       out_ready,
  output mep_out_t                   out_data,
  // register writes
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  // command and status between sequencer and datapath
  mep_cmd_t    cmd;
  mep_status_t st;

  // sequencer: offsets, iteration loop, division, output handoff
  mep_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // registers, shared multiplier, color divider, output register
  mep_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule
